@@ src/plfc_pkg.sv @@
// Shared types, codes, pattern table and lamp update functions of the panel lamp flash controller.
package plfc_pkg;

    // Number of lamps with a flash timer; lamp fields keep their fixed 8-bit width.
    localparam int LAMP_COUNT  = 8;
    localparam int LAMP_WIDTH  = 8;
    localparam int COUNT_WIDTH = 16;

    // Lamp bits that have a timer behind them.
    localparam logic [LAMP_WIDTH-1:0] LAMP_BITS_MASK = LAMP_WIDTH'((1 << LAMP_COUNT) - 1);

    // Item kinds.
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_DIRECT = 2'd1;
    localparam logic [1:0] ACT_STEP   = 2'd2;
    localparam logic [1:0] ACT_ALARM  = 2'd3;

    // Direct command modes; the unused code behaves as off.
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_FLASH = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FLASH_PERIOD    = 1'b0;
    localparam logic CFG_PANEL_LAMP_MASK = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COUNT_WIDTH-1:0] FLASH_PERIOD_RESET    = 16'd50;
    localparam logic [LAMP_WIDTH-1:0]  PANEL_LAMP_MASK_RESET = 8'hFF;

    // Step and alarm lamp patterns.
    localparam logic [LAMP_WIDTH-1:0] PATTERN_TABLE [16] = '{
        8'h00, 8'h40, 8'h20, 8'h60, 8'h02, 8'h42, 8'h22, 8'h62,
        8'h01, 8'h41, 8'h21, 8'h61, 8'h03, 8'h43, 8'h23, 8'h63
    };

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef count_t [LAMP_COUNT-1:0] count_vec_t;

    // One input item.
    typedef struct packed {
        logic [1:0]            action;
        logic [LAMP_WIDTH-1:0] lamp_select;
        logic [1:0]            lamp_mode;
        logic [3:0]            pattern_index;
    } plfc_item_t;

    // One result item.
    typedef struct packed {
        logic [LAMP_WIDTH-1:0] lamp_drive;
        logic                  drive_written;
    } plfc_result_t;

    // Lamp state as one value.
    typedef struct packed {
        logic [LAMP_WIDTH-1:0] lamp_bits;
        logic [LAMP_WIDTH-1:0] flash_bits;
        count_vec_t            countdown;
    } lamp_state_t;

    // Off, on or flash command for a set of lamps.
    function automatic lamp_state_t lamp_cmd(input lamp_state_t st,
                                             input logic [LAMP_WIDTH-1:0] sel,
                                             input logic [1:0] mode,
                                             input count_t period);
        lamp_state_t nx;
        logic        any_sel;
        nx      = st;
        any_sel = |(sel & LAMP_BITS_MASK);
        for (int n = 0; n < LAMP_COUNT; n++)
        begin
            if (sel[n])
            begin
                if (mode == MODE_FLASH)
                begin
                    nx.countdown[n] = period;
                end
                else
                begin
                    nx.countdown[n]  = '0;
                    nx.flash_bits[n] = 1'b0;
                end
            end
        end
        if (any_sel)
        begin
            if (mode == MODE_FLASH)
            begin
                // The whole flash mask is replaced, not merged.
                nx.flash_bits = sel;
                nx.lamp_bits  = st.lamp_bits | sel;
            end
            else if (mode == MODE_ON)
            begin
                nx.lamp_bits = st.lamp_bits | sel;
            end
            else
            begin
                nx.lamp_bits = st.lamp_bits & ~sel;
            end
        end
        return nx;
    endfunction

    // One tick: every flashing timer counts down, reloads and toggles at zero.
    function automatic lamp_state_t lamp_tick(input lamp_state_t st, input count_t period);
        lamp_state_t nx;
        count_t      dec;
        nx = st;
        for (int n = 0; n < LAMP_COUNT; n++)
        begin
            dec = st.countdown[n] - 1'b1;
            if (st.flash_bits[n])
            begin
                if (dec == '0)
                begin
                    nx.countdown[n] = period;
                    nx.lamp_bits[n] = ~st.lamp_bits[n];
                end
                else
                begin
                    nx.countdown[n] = dec;
                end
            end
        end
        return nx;
    endfunction

endpackage

@@ src/plfc_in_reg.sv @@
// Input register stage of the panel lamp flash controller.
module plfc_in_reg
    import plfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // lamp_select[7:0], lamp_mode[9:8], pattern_index[13:10]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    input  logic       advance,
    output logic       item_valid,
    output plfc_item_t item
);

    logic       valid_reg;
    plfc_item_t item_reg;
    logic       accept;

    // The register takes a new item when empty or when its item moves on.
    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action        <= s_axis_tuser;
            item_reg.lamp_select   <= s_axis_tdata[7:0];
            item_reg.lamp_mode     <= s_axis_tdata[9:8];
            item_reg.pattern_index <= s_axis_tdata[13:10];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    // A held item stays while it cannot move on.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !advance |=> valid_reg)
        else $error("plfc_in_reg: held item dropped");

endmodule

@@ src/plfc_lamp_state.sv @@
// Lamp, flash and timer state with configuration registers and the single-pass update.
module plfc_lamp_state
    import plfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  fire,
    input  plfc_item_t            item,
    output plfc_result_t          result
);

    logic [COUNT_WIDTH-1:0] flash_period_reg;
    logic [LAMP_WIDTH-1:0]  panel_lamp_mask_reg;
    lamp_state_t            state_reg;
    lamp_state_t            state_next;
    lamp_state_t            cleared;
    logic                   wrote;
    logic                   clear_wrote;
    logic                   pattern_wrote;
    logic [LAMP_WIDTH-1:0]  pattern;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_period_reg    <= FLASH_PERIOD_RESET;
            panel_lamp_mask_reg <= PANEL_LAMP_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLASH_PERIOD:    flash_period_reg    <= cfg_data;
                CFG_PANEL_LAMP_MASK: panel_lamp_mask_reg <= cfg_data[LAMP_WIDTH-1:0];
                default:             flash_period_reg    <= flash_period_reg;
            endcase
        end
    end

    // Step and alarm first switch the panel lamps off, then apply the pattern.
    assign pattern       = PATTERN_TABLE[item.pattern_index];
    assign clear_wrote   = |(panel_lamp_mask_reg & LAMP_BITS_MASK);
    assign pattern_wrote = |(pattern & LAMP_BITS_MASK);
    assign cleared       = lamp_cmd(state_reg, panel_lamp_mask_reg, MODE_OFF, flash_period_reg);

    // Next state for the item in hand.
    always_comb
    begin
        state_next = state_reg;
        wrote      = 1'b0;
        unique case (item.action)
            ACT_TICK:
            begin
                if (state_reg.flash_bits != '0)
                begin
                    state_next = lamp_tick(state_reg, flash_period_reg);
                    wrote      = 1'b1;
                end
            end
            ACT_DIRECT:
            begin
                state_next = lamp_cmd(state_reg, item.lamp_select, item.lamp_mode,
                                      flash_period_reg);
                wrote      = |(item.lamp_select & LAMP_BITS_MASK);
            end
            ACT_STEP:
            begin
                state_next = lamp_cmd(cleared, pattern, MODE_ON, flash_period_reg);
                wrote      = clear_wrote || pattern_wrote;
            end
            ACT_ALARM:
            begin
                state_next = lamp_cmd(cleared, pattern, MODE_FLASH, flash_period_reg);
                wrote      = clear_wrote || pattern_wrote;
            end
            default:
            begin
                state_next = state_reg;
                wrote      = 1'b0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result of this item, active-low drive of the existing lamps.
    assign result.lamp_drive    = ~state_next.lamp_bits & panel_lamp_mask_reg;
    assign result.drive_written = wrote;

    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("plfc_lamp_state: state changed without an item");

    a_quiet_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_TICK && state_reg.flash_bits == '0
        |=> $stable(state_reg.lamp_bits))
        else $error("plfc_lamp_state: lamps changed on a tick without flashing lamps");

    a_step_no_flash: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == ACT_STEP
        |=> (state_reg.flash_bits & $past(panel_lamp_mask_reg) & LAMP_BITS_MASK) == '0)
        else $error("plfc_lamp_state: step left a panel lamp flashing");

endmodule

@@ src/panel_lamp_flash_controller_core.sv @@
// Top level of the panel lamp flash controller: input stage, lamp state and result register.
//
// The block takes one item per clock cycle while results are taken, and gives one result per
// item. An accepted item waits in the input register until the output register is free. Then a
// single pass through the lamp update, which steps all eight flash timers side by side, loads
// its result into the output register, from which it is offered. When the output side is ready
// every cycle, items and results flow back to back. While a result waits for the output side,
// the input register still takes one more item. After that the input stalls until the waiting
// result is taken. Configuration writes take effect on the next clock edge and are meant to be
// made while no item is in flight.
module panel_lamp_flash_controller_core
    import plfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // lamp_select[7:0], lamp_mode[9:8], pattern_index[13:10]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // lamp_drive[7:0]
    output logic        m_axis_tuser   // drive_written[0]
);

    logic         item_valid;
    plfc_item_t   item;
    logic         advance;
    plfc_result_t result;
    logic         out_valid_reg;
    plfc_result_t out_reg;

    // The item in the input register moves on when the output register is free.
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    plfc_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    plfc_lamp_state u_lamp_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (item),
        .result    (result)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.lamp_drive;
    assign m_axis_tuser  = out_reg.drive_written;

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("panel_lamp_flash_controller_core: result lost after update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !advance)
        else $error("panel_lamp_flash_controller_core: waiting result overwritten");

    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_axis_tready)
        else $error("panel_lamp_flash_controller_core: empty input stage not ready");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the panel lamp flash controller core.
module tb;
    import plfc_pkg::*;

    // The spare mode code decodes as off.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Cycles without any handshake before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 2000;

    // Lamp patterns used by the step and alarm commands.
    localparam logic [7:0] LAMP_PATTERNS [16] = '{
        8'h00, 8'h40, 8'h20, 8'h60, 8'h02, 8'h42, 8'h22, 8'h62,
        8'h01, 8'h41, 8'h21, 8'h61, 8'h03, 8'h43, 8'h23, 8'h63
    };

    // Register settings visited by the random part, one per chunk of items.
    localparam logic [15:0] PERIOD_PLAN [9] = '{
        16'd2, 16'd0, 16'd7, 16'hFFFF, 16'd1, 16'd4, 16'd3, 16'd1, 16'd5
    };
    localparam logic [7:0] MASK_PLAN [9] = '{
        8'hFF, 8'hA5, 8'h0F, 8'hFF, 8'h00, 8'hF3, 8'hFF, 8'h7E, 8'hFF
    };

    // One line of the directed script: either a register write or an item.
    typedef struct {
        bit           is_reg;
        logic         reg_idx;
        logic [15:0]  reg_val;
        plfc_item_t   cmd;
        bit           typed;
        plfc_result_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // lamp_select[7:0], lamp_mode[9:8], pattern_index[13:10]
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // lamp_drive[7:0]
    logic        m_axis_tuser;   // drive_written[0]

    // Shadow copy of the lamp state and the registers.
    logic [15:0] period_q;
    logic [7:0]  panel_mask_q;
    logic [7:0]  lit_q;
    logic [7:0]  flashing_q;
    logic [15:0] timer_q [LAMP_COUNT];

    plfc_result_t drives_due [$];
    plfc_result_t drive_head;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int          errors        = 0;
    int          items_sent    = 0;
    int          directed_sent = 0;
    int          results_seen  = 0;
    int          writes_seen   = 0;
    int          reg_writes    = 0;

    panel_lamp_flash_controller_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Off, on or flash command on the shadow state; returns whether the port is written.
    function automatic logic apply_lamp_cmd(input logic [7:0] sel, input logic [1:0] mode);
        logic [7:0] reach;
        reach = 8'((1 << LAMP_COUNT) - 1) & sel;
        if (reach == '0)
            return 1'b0;
        for (int n = 0; n < LAMP_COUNT; n++)
        begin
            if (sel[n])
                timer_q[n] = (mode == MODE_FLASH) ? period_q : 16'd0;
        end
        if (mode == MODE_FLASH)
        begin
            // A flash command replaces the flash set rather than adding to it.
            flashing_q = sel;
            lit_q      = lit_q | sel;
        end
        else
        begin
            flashing_q = flashing_q & ~reach;
            if (mode == MODE_ON)
                lit_q = lit_q | sel;
            else
                lit_q = lit_q & ~sel;
        end
        return 1'b1;
    endfunction

    // Tick on the shadow state: flashing timers count down and toggle their lamp at zero.
    function automatic logic apply_tick();
        if (flashing_q == '0)
            return 1'b0;
        for (int n = 0; n < LAMP_COUNT; n++)
        begin
            if (flashing_q[n])
            begin
                // A timer already at zero wraps around without a toggle.
                timer_q[n] = timer_q[n] - 16'd1;
                if (timer_q[n] == '0)
                begin
                    timer_q[n] = period_q;
                    lit_q[n]   = ~lit_q[n];
                end
            end
        end
        return 1'b1;
    endfunction

    // Advances the shadow state by one item and returns the lamp drive it should produce.
    function automatic plfc_result_t next_lamp_drive(input plfc_item_t cmd);
        plfc_result_t res;
        logic         cleared;
        logic         lit;
        case (cmd.action)
            ACT_TICK:
                res.drive_written = apply_tick();
            ACT_DIRECT:
                res.drive_written = apply_lamp_cmd(cmd.lamp_select, cmd.lamp_mode);
            ACT_STEP:
            begin
                cleared = apply_lamp_cmd(panel_mask_q, MODE_OFF);
                lit     = apply_lamp_cmd(LAMP_PATTERNS[cmd.pattern_index], MODE_ON);
                res.drive_written = cleared | lit;
            end
            default:
            begin
                cleared = apply_lamp_cmd(panel_mask_q, MODE_OFF);
                lit     = apply_lamp_cmd(LAMP_PATTERNS[cmd.pattern_index], MODE_FLASH);
                res.drive_written = cleared | lit;
            end
        endcase
        res.lamp_drive = ~lit_q & panel_mask_q;
        return res;
    endfunction

    // Random item: mostly ticks and direct commands, with steps and alarms mixed in.
    function automatic plfc_item_t random_item();
        plfc_item_t  cmd;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            cmd.action = ACT_TICK;
        else if (pick < 75)
            cmd.action = ACT_DIRECT;
        else if (pick < 87)
            cmd.action = ACT_ALARM;
        else
            cmd.action = ACT_STEP;
        pick = $urandom_range(99);
        if (pick < 12)
            cmd.lamp_select = 8'h00;
        else if (pick < 45)
            cmd.lamp_select = 8'(1 << $urandom_range(7));
        else
            cmd.lamp_select = 8'($urandom);
        cmd.lamp_mode     = 2'($urandom_range(3));
        cmd.pattern_index = 4'($urandom_range(15));
        return cmd;
    endfunction

    function automatic script_row_t item_row(input logic [1:0] act, input logic [7:0] sel,
                                             input logic [1:0] mode, input logic [3:0] idx,
                                             input bit typed, input logic [7:0] drive,
                                             input logic written);
        script_row_t row;
        row.is_reg                 = 1'b0;
        row.reg_idx                = 1'b0;
        row.reg_val                = '0;
        row.cmd.action             = act;
        row.cmd.lamp_select        = sel;
        row.cmd.lamp_mode          = mode;
        row.cmd.pattern_index      = idx;
        row.typed                  = typed;
        row.want.lamp_drive        = drive;
        row.want.drive_written     = written;
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic idx, input logic [15:0] val);
        script_row_t row;
        row         = item_row(ACT_TICK, 8'h00, MODE_OFF, 4'd0, 1'b0, 8'h00, 1'b0);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // Offers one item, waits for it to be taken and records the drive it should produce.
    // Starts and ends on a falling edge.
    task automatic offer_item(input plfc_item_t cmd, input bit typed, input plfc_result_t want);
        plfc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd.action;
        s_axis_tdata  <= {2'b00, cmd.pattern_index, cmd.lamp_mode, cmd.lamp_select};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = next_lamp_drive(cmd);
        drives_due.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // Writes a register once every expected drive has come out and the pipe has drained.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        s_axis_tvalid <= 1'b0;
        while (drives_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FLASH_PERIOD)
            period_q = val;
        else
            panel_mask_q = val[7:0];
        reg_writes++;
        @(negedge clk);
    endtask

    // Directed script: corners of every command and of the registers.
    task automatic run_directed();
        script_row_t script [$];
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  1, 8'hFF, 1'b0));
        script.push_back(item_row(ACT_DIRECT, 8'h00, MODE_ON,    4'd0,  1, 8'hFF, 1'b0));
        script.push_back(item_row(ACT_DIRECT, 8'hFF, MODE_ON,    4'd0,  1, 8'h00, 1'b1));
        script.push_back(item_row(ACT_DIRECT, 8'h0F, MODE_OFF,   4'd0,  1, 8'h0F, 1'b1));
        script.push_back(item_row(ACT_DIRECT, 8'hF0, MODE_SPARE, 4'd0,  1, 8'hFF, 1'b1));
        script.push_back(item_row(ACT_DIRECT, 8'h81, MODE_FLASH, 4'd0,  1, 8'h7E, 1'b1));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_DIRECT, 8'h01, MODE_ON,    4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_STEP,   8'h00, MODE_OFF,   4'd15, 1, 8'h9C, 1'b1));
        script.push_back(item_row(ACT_ALARM,  8'h00, MODE_OFF,   4'd0,  1, 8'hFF, 1'b1));
        script.push_back(item_row(ACT_ALARM,  8'h00, MODE_OFF,   4'd7,  1, 8'h9D, 1'b1));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  0, 8'h00, 1'b0));
        // A zero period leaves a flashing timer at zero, so the next tick wraps it.
        script.push_back(reg_row(CFG_FLASH_PERIOD, 16'd0));
        script.push_back(item_row(ACT_DIRECT, 8'h01, MODE_FLASH, 4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  0, 8'h00, 1'b0));
        // Period one toggles every flashing lamp on every tick.
        script.push_back(reg_row(CFG_FLASH_PERIOD, 16'd1));
        script.push_back(item_row(ACT_DIRECT, 8'hFF, MODE_FLASH, 4'd0,  1, 8'h00, 1'b1));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  1, 8'hFF, 1'b1));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  1, 8'h00, 1'b1));
        // With no panel lamps the clearing pass writes nothing, so an empty alarm writes nothing.
        script.push_back(reg_row(CFG_PANEL_LAMP_MASK, 16'h0000));
        script.push_back(item_row(ACT_STEP,   8'h00, MODE_OFF,   4'd3,  1, 8'h00, 1'b1));
        script.push_back(item_row(ACT_ALARM,  8'h00, MODE_OFF,   4'd0,  1, 8'h00, 1'b0));
        script.push_back(reg_row(CFG_PANEL_LAMP_MASK, 16'h00FF));
        script.push_back(reg_row(CFG_FLASH_PERIOD, 16'hFFFF));
        script.push_back(item_row(ACT_DIRECT, 8'h55, MODE_FLASH, 4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_TICK,   8'h00, MODE_OFF,   4'd0,  0, 8'h00, 1'b0));
        script.push_back(item_row(ACT_STEP,   8'h00, MODE_OFF,   4'd12, 0, 8'h00, 1'b0));
        foreach (script[i])
        begin
            if (script[i].is_reg)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
            begin
                offer_item(script[i].cmd, script[i].typed, script[i].want);
                directed_sent++;
            end
        end
    endtask

    // Output side: random back-pressure plus one long hold-off when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each drive that leaves the block is compared with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drives_due.size() == 0)
            begin
                $error("unexpected lamp drive %h, written %b", m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                drive_head = drives_due.pop_front();
                if (m_axis_tdata !== drive_head.lamp_drive)
                begin
                    $error("lamp_drive: expected %h, got %h", drive_head.lamp_drive,
                           m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== drive_head.drive_written)
                begin
                    $error("drive_written: expected %b, got %b", drive_head.drive_written,
                           m_axis_tuser);
                    errors++;
                end
            end
            results_seen++;
            if (m_axis_tuser)
                writes_seen++;
        end
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("no item moved for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Reset, directed script, three random phases, then drain and report.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FLASH_PERIOD;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_TICK;
        period_q      = 16'd50;
        panel_mask_q  = 8'hFF;
        lit_q         = '0;
        flashing_q    = '0;
        foreach (timer_q[n])
            timer_q[n] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 23 : 0;
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                write_reg(CFG_FLASH_PERIOD, PERIOD_PLAN[phase * 3 + chunk]);
                write_reg(CFG_PANEL_LAMP_MASK, 16'(MASK_PLAN[phase * 3 + chunk]));
                // Stall the output for a long stretch while items keep coming.
                if (phase == 2 && chunk == 0)
                    hold_left = 90;
                repeat (200) offer_item(random_item(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (drives_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d items (%0d directed) across %0d register writes, idling each side",
                 items_sent, directed_sent, reg_writes);
        $display("in turn and holding the output off once; %0d drives checked, %0d written.",
                 results_seen, writes_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
